### design/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define EFD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication checked on every rising clock edge outside reset
`define EFD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

### design/efd_pkg.sv
// types and constants of the escaped frame deframer
package efd_pkg;

  typedef logic [7:0]  byte_t;
  typedef logic [15:0] word_t;
  typedef logic [16:0] pos_t;
  typedef logic [1:0]  cfg_idx_t;

  typedef enum logic {
    KindPayload = 1'b0,
    KindEnd     = 1'b1
  } kind_e;

  localparam cfg_idx_t CfgStart  = 2'd0;
  localparam cfg_idx_t CfgEscape = 2'd1;
  localparam cfg_idx_t CfgPad    = 2'd2;

  localparam byte_t ResetStart  = 8'd126;
  localparam byte_t ResetEscape = 8'd125;
  localparam byte_t ResetPad    = 8'd32;

  localparam pos_t PosHunt   = 17'd0;
  localparam pos_t PosLenHi  = 17'd1;
  localparam pos_t PosLenLo  = 17'd2;
  localparam pos_t PosSource = 17'd3;
  localparam pos_t PosRssiHi = 17'd4;
  localparam pos_t PosRssiLo = 17'd5;
  localparam pos_t PosSnrHi  = 17'd6;
  localparam pos_t PosSnrLo  = 17'd7;
  localparam pos_t PosType   = 17'd8;
  localparam pos_t PosFirstPayload = 17'd9;
  localparam pos_t TrailerOffset   = 17'd2;

  localparam word_t MinLength    = 16'd7;
  localparam byte_t ChecksumBase = 8'hFF;

endpackage

### design/efd_ifs.sv
// valid/ready channels for raw bytes and deframed results
interface efd_rx_if;
  logic           valid;
  logic           ready;
  efd_pkg::byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface efd_res_if;
  logic              valid;
  logic              ready;
  efd_pkg::kind_e    kind;
  efd_pkg::byte_t    payload_data;
  efd_pkg::word_t    payload_index;
  efd_pkg::byte_t    source_address;
  efd_pkg::word_t    signal_strength;
  efd_pkg::word_t    noise_ratio;
  efd_pkg::byte_t    frame_type;
  efd_pkg::word_t    payload_length;
  logic              checksum_ok;
  logic              length_error;

  modport source (output valid, output kind, output payload_data, output payload_index,
                  output source_address, output signal_strength, output noise_ratio,
                  output frame_type, output payload_length, output checksum_ok,
                  output length_error, input ready);
  modport sink (input valid, input kind, input payload_data, input payload_index,
                input source_address, input signal_strength, input noise_ratio,
                input frame_type, input payload_length, input checksum_ok,
                input length_error, output ready);
endinterface

### design/escaped_frame_deframer_top.sv
// escaped frame deframer: byte-stuffed frame decode with header capture and checksum
//
// rx_i carries one raw link byte per beat. res_o carries one result beat per
// payload byte (kind payload, with its index) and one frame-end beat carrying
// the header fields, payload length, checksum status and length error.
// header bytes, escapes and bytes outside a frame give no beat; the checksum byte gives the frame-end beat.
// cfg_we_i writes start value, escape value or pad mask by cfg_idx_i; write
// only while the block is idle.
// a result is registered and appears on res_o in the cycle after its byte is taken.
// throughput: one byte per cycle; the decode sits between the byte handshake
// and the single result register, so rx_i.ready is high whenever that
// register is empty or being drained in the same cycle.
// when the receiver stalls, the held result stays and rx_i.ready drops until
// it is taken; no byte is lost.
// reset returns the registers to 126, 125 and 32, empties the result
// register and puts the block in start hunting.
module escaped_frame_deframer_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  efd_pkg::cfg_idx_t   cfg_idx_i,
  input  efd_pkg::byte_t      cfg_wdata_i,
  efd_rx_if.sink              rx_i,
  efd_res_if.source           res_o
);

  efd_pkg::byte_t start_q, escape_q, pad_q;
  efd_pkg::pos_t  pos_q, pos_d;
  logic           esc_q, esc_d;
  efd_pkg::word_t len_q, len_d;
  efd_pkg::byte_t src_q, src_d;
  efd_pkg::word_t rssi_q, rssi_d;
  efd_pkg::word_t snr_q, snr_d;
  efd_pkg::byte_t type_q, type_d;
  efd_pkg::byte_t sum_q, sum_d;

  logic           out_valid_q, out_valid_d;
  efd_pkg::kind_e kind_q, kind_d;
  efd_pkg::byte_t data_q, data_d;
  efd_pkg::word_t index_q, index_d;
  efd_pkg::byte_t osrc_q, osrc_d;
  efd_pkg::word_t orssi_q, orssi_d;
  efd_pkg::word_t osnr_q, osnr_d;
  efd_pkg::byte_t otype_q, otype_d;
  efd_pkg::word_t olen_q, olen_d;
  logic           ocks_q, ocks_d;
  logic           olerr_q, olerr_d;

  logic           accept;
  logic           emit;
  efd_pkg::byte_t raw;
  efd_pkg::byte_t decoded;
  efd_pkg::pos_t  end_pos;
  efd_pkg::pos_t  idx_full;

  assign rx_i.ready = !out_valid_q || res_o.ready;
  assign accept     = rx_i.valid && rx_i.ready;
  assign raw        = rx_i.rx_byte;
  assign decoded    = esc_q ? (raw ^ pad_q) : raw;
  assign end_pos    = {1'b0, len_q} + efd_pkg::TrailerOffset;
  assign idx_full   = pos_q - efd_pkg::PosFirstPayload;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= efd_pkg::ResetStart;
      escape_q <= efd_pkg::ResetEscape;
      pad_q    <= efd_pkg::ResetPad;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        efd_pkg::CfgStart:  start_q  <= cfg_wdata_i;
        efd_pkg::CfgEscape: escape_q <= cfg_wdata_i;
        efd_pkg::CfgPad:    pad_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // per-byte decode
  always_comb begin
    pos_d   = pos_q;
    esc_d   = esc_q;
    len_d   = len_q;
    src_d   = src_q;
    rssi_d  = rssi_q;
    snr_d   = snr_q;
    type_d  = type_q;
    sum_d   = sum_q;
    emit    = 1'b0;
    kind_d  = efd_pkg::KindPayload;
    data_d  = '0;
    index_d = '0;
    osrc_d  = '0;
    orssi_d = '0;
    osnr_d  = '0;
    otype_d = '0;
    olen_d  = '0;
    ocks_d  = 1'b0;
    olerr_d = 1'b0;
    if (accept) begin
      if (raw == start_q) begin
        pos_d = efd_pkg::PosLenHi;
        esc_d = 1'b0;
      end else if (pos_q == efd_pkg::PosHunt) begin
        // hunting, byte dropped
      end else if (!esc_q && (raw == escape_q)) begin
        esc_d = 1'b1;
      end else begin
        esc_d = 1'b0;
        pos_d = pos_q + 17'd1;
        case (pos_q)
          efd_pkg::PosLenHi:  len_d = {decoded, 8'd0};
          efd_pkg::PosLenLo:  len_d = {len_q[15:8], decoded};
          efd_pkg::PosSource: begin
            src_d = decoded;
            sum_d = decoded;
          end
          efd_pkg::PosRssiHi: begin
            rssi_d = {decoded, 8'd0};
            sum_d  = sum_q + decoded;
          end
          efd_pkg::PosRssiLo: begin
            rssi_d = {rssi_q[15:8], decoded};
            sum_d  = sum_q + decoded;
          end
          efd_pkg::PosSnrHi: begin
            snr_d = {decoded, 8'd0};
            sum_d = sum_q + decoded;
          end
          efd_pkg::PosSnrLo: begin
            snr_d = {snr_q[15:8], decoded};
            sum_d = sum_q + decoded;
          end
          efd_pkg::PosType: begin
            type_d = decoded;
            sum_d  = sum_q + decoded;
          end
          default: begin
            emit = 1'b1;
            if (pos_q >= end_pos) begin
              // checksum byte closes the frame
              kind_d  = efd_pkg::KindEnd;
              osrc_d  = src_q;
              orssi_d = rssi_q;
              osnr_d  = snr_q;
              otype_d = type_q;
              olerr_d = (len_q < efd_pkg::MinLength);
              olen_d  = olerr_d ? '0 : (len_q - efd_pkg::MinLength);
              ocks_d  = ((efd_pkg::ChecksumBase - sum_q) == decoded);
              pos_d   = efd_pkg::PosHunt;
              sum_d   = '0;
            end else begin
              data_d  = decoded;
              index_d = idx_full[15:0];
              sum_d   = sum_q + decoded;
            end
          end
        endcase
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= efd_pkg::PosHunt;
      esc_q       <= 1'b0;
      len_q       <= '0;
      src_q       <= '0;
      rssi_q      <= '0;
      snr_q       <= '0;
      type_q      <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      esc_q       <= esc_d;
      len_q       <= len_d;
      src_q       <= src_d;
      rssi_q      <= rssi_d;
      snr_q       <= snr_d;
      type_q      <= type_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q  <= kind_d;
      data_q  <= data_d;
      index_q <= index_d;
      osrc_q  <= osrc_d;
      orssi_q <= orssi_d;
      osnr_q  <= osnr_d;
      otype_q <= otype_d;
      olen_q  <= olen_d;
      ocks_q  <= ocks_d;
      olerr_q <= olerr_d;
    end
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.kind            = kind_q;
  assign res_o.payload_data    = data_q;
  assign res_o.payload_index   = index_q;
  assign res_o.source_address  = osrc_q;
  assign res_o.signal_strength = orssi_q;
  assign res_o.noise_ratio     = osnr_q;
  assign res_o.frame_type      = otype_q;
  assign res_o.payload_length  = olen_q;
  assign res_o.checksum_ok     = ocks_q;
  assign res_o.length_error    = olerr_q;

endmodule

### design/efd_checker.sv
// port-level checker for the escaped frame deframer, with its bind
`include "assert_macros.svh"

module efd_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           rx_valid_i,
  input logic           rx_ready_i,
  input logic           res_valid_i,
  input logic           res_ready_i,
  input efd_pkg::kind_e kind_i,
  input efd_pkg::byte_t payload_data_i,
  input efd_pkg::word_t payload_index_i,
  input efd_pkg::byte_t source_address_i,
  input efd_pkg::word_t payload_length_i,
  input logic           checksum_ok_i,
  input logic           length_error_i
);

  `EFD_ASSERT(a_res_hold, res_valid_i && !res_ready_i |=> res_valid_i, "result beat dropped")
  `EFD_ASSERT_IMPL(a_beat_from_byte, $rose(res_valid_i), $past(rx_valid_i && rx_ready_i), "result without byte")
  `EFD_ASSERT_IMPL(a_end_clean, res_valid_i && (kind_i == efd_pkg::KindEnd), (payload_data_i == '0) && (payload_index_i == '0), "frame end carries payload")
  `EFD_ASSERT_IMPL(a_payload_clean, res_valid_i && (kind_i == efd_pkg::KindPayload), (source_address_i == '0) && !checksum_ok_i && !length_error_i, "payload beat carries header")
  `EFD_ASSERT_IMPL(a_len_err_zero, res_valid_i && length_error_i, payload_length_i == '0, "length error with nonzero length")

endmodule

bind escaped_frame_deframer_top efd_checker u_efd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .rx_valid_i       (rx_i.valid),
  .rx_ready_i       (rx_i.ready),
  .res_valid_i      (res_o.valid),
  .res_ready_i      (res_o.ready),
  .kind_i           (res_o.kind),
  .payload_data_i   (res_o.payload_data),
  .payload_index_i  (res_o.payload_index),
  .source_address_i (res_o.source_address),
  .payload_length_i (res_o.payload_length),
  .checksum_ok_i    (res_o.checksum_ok),
  .length_error_i   (res_o.length_error)
);

### sim/escaped_frame_deframer_top_test.sv
// self-checking testbench for the escaped frame deframer top level
module escaped_frame_deframer_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 3000000;
  localparam int unsigned HoldCycles = 120;
  localparam int unsigned PhaseBytes = 150;

  typedef struct packed {
    efd_pkg::kind_e kind;
    efd_pkg::byte_t payload_data;
    efd_pkg::word_t payload_index;
    efd_pkg::byte_t source_address;
    efd_pkg::word_t signal_strength;
    efd_pkg::word_t noise_ratio;
    efd_pkg::byte_t frame_type;
    efd_pkg::word_t payload_length;
    logic           checksum_ok;
    logic           length_error;
  } frame_result_t;

  typedef enum int unsigned {
    TakeAll,
    TakeCoin,
    TakeMost,
    TakePattern
  } take_mode_e;

  class deframe_predictor;
    efd_pkg::byte_t start_val;
    efd_pkg::byte_t esc_val;
    efd_pkg::byte_t pad;
    efd_pkg::pos_t position;
    bit esc_pending;
    efd_pkg::word_t length_fld;
    efd_pkg::byte_t src;
    efd_pkg::word_t rssi;
    efd_pkg::word_t snr;
    efd_pkg::byte_t ftype;
    efd_pkg::byte_t sum;
    frame_result_t due_results[$];
    int unsigned failures;

    function new();
      start_val = efd_pkg::ResetStart;
      esc_val = efd_pkg::ResetEscape;
      pad = efd_pkg::ResetPad;
      position = efd_pkg::PosHunt;
      esc_pending = 1'b0;
      length_fld = '0;
      src = '0;
      rssi = '0;
      snr = '0;
      ftype = '0;
      sum = '0;
      failures = 0;
    endfunction

    function void set_reg(efd_pkg::cfg_idx_t idx, efd_pkg::byte_t value);
      case (idx)
        efd_pkg::CfgStart: start_val = value;
        efd_pkg::CfgEscape: esc_val = value;
        efd_pkg::CfgPad: pad = value;
        default: ;
      endcase
    endfunction

    // one accepted raw byte, queues the result beat it causes
    function void decode_byte(efd_pkg::byte_t raw);
      efd_pkg::byte_t b;
      efd_pkg::byte_t chk;
      frame_result_t r;
      b = raw;
      r = '0;
      if (b == start_val) begin
        position = efd_pkg::PosLenHi;
        esc_pending = 1'b0;
        return;
      end
      if (position == efd_pkg::PosHunt) return;
      if (esc_pending) begin
        b = b ^ pad;
        esc_pending = 1'b0;
      end else if (b == esc_val) begin
        esc_pending = 1'b1;
        return;
      end
      case (position)
        efd_pkg::PosLenHi: length_fld = {b, 8'h00};
        efd_pkg::PosLenLo: length_fld = {length_fld[15:8], b};
        efd_pkg::PosSource: begin
          src = b;
          sum = b;
        end
        efd_pkg::PosRssiHi: begin
          rssi = {b, 8'h00};
          sum = sum + b;
        end
        efd_pkg::PosRssiLo: begin
          rssi = {rssi[15:8], b};
          sum = sum + b;
        end
        efd_pkg::PosSnrHi: begin
          snr = {b, 8'h00};
          sum = sum + b;
        end
        efd_pkg::PosSnrLo: begin
          snr = {snr[15:8], b};
          sum = sum + b;
        end
        efd_pkg::PosType: begin
          ftype = b;
          sum = sum + b;
        end
        default: begin
          if (position >= {1'b0, length_fld} + efd_pkg::TrailerOffset) begin
            chk = efd_pkg::ChecksumBase - sum;
            r.kind = efd_pkg::KindEnd;
            r.source_address = src;
            r.signal_strength = rssi;
            r.noise_ratio = snr;
            r.frame_type = ftype;
            r.payload_length = (length_fld >= efd_pkg::MinLength) ?
                               length_fld - efd_pkg::MinLength : '0;
            r.checksum_ok = (chk == b);
            r.length_error = (length_fld < efd_pkg::MinLength);
            due_results.push_back(r);
            position = efd_pkg::PosHunt;
            sum = '0;
            return;
          end
          sum = sum + b;
          r.kind = efd_pkg::KindPayload;
          r.payload_data = b;
          r.payload_index = efd_pkg::word_t'(position - efd_pkg::PosFirstPayload);
          due_results.push_back(r);
        end
      endcase
      position = position + 17'd1;
    endfunction

    function void check_field(string field, efd_pkg::word_t want, efd_pkg::word_t got);
      if (want != got) begin
        $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        failures++;
      end
    endfunction

    function void take_result(frame_result_t got);
      frame_result_t want;
      if (due_results.size() == 0) begin
        $error("result beat with nothing due, kind %0d", got.kind);
        failures++;
        return;
      end
      want = due_results.pop_front();
      check_field("kind", efd_pkg::word_t'(want.kind), efd_pkg::word_t'(got.kind));
      check_field("payload_data", efd_pkg::word_t'(want.payload_data),
                  efd_pkg::word_t'(got.payload_data));
      check_field("payload_index", want.payload_index, got.payload_index);
      check_field("source_address", efd_pkg::word_t'(want.source_address),
                  efd_pkg::word_t'(got.source_address));
      check_field("signal_strength", want.signal_strength, got.signal_strength);
      check_field("noise_ratio", want.noise_ratio, got.noise_ratio);
      check_field("frame_type", efd_pkg::word_t'(want.frame_type),
                  efd_pkg::word_t'(got.frame_type));
      check_field("payload_length", want.payload_length, got.payload_length);
      check_field("checksum_ok", efd_pkg::word_t'(want.checksum_ok),
                  efd_pkg::word_t'(got.checksum_ok));
      check_field("length_error", efd_pkg::word_t'(want.length_error),
                  efd_pkg::word_t'(got.length_error));
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  efd_pkg::cfg_idx_t cfg_idx_i;
  efd_pkg::byte_t cfg_wdata_i;

  efd_rx_if rx_if();
  efd_res_if res_if();

  deframe_predictor fd = new();
  efd_pkg::byte_t raw_q[$];
  bit hold_req = 1'b0;

  escaped_frame_deframer_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .rx_i       (rx_if),
    .res_o      (res_if)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    for (int unsigned cycle_count = 0; cycle_count < CycleLimit; cycle_count++) begin
      @(posedge clk_i);
    end
    $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      fd.take_result({res_if.kind, res_if.payload_data, res_if.payload_index,
                      res_if.source_address, res_if.signal_strength, res_if.noise_ratio,
                      res_if.frame_type, res_if.payload_length, res_if.checksum_ok,
                      res_if.length_error});
    end
  end

  // result receiver: changing stall modes plus requested long hold-offs
  initial begin
    take_mode_e mode;
    int unsigned left;
    efd_pkg::byte_t stall_bits;
    res_if.ready <= 1'b0;
    mode = TakeAll;
    left = 0;
    stall_bits = 8'hFF;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        res_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end
      if (left == 0) begin
        mode = take_mode_e'($urandom_range(0, 3));
        left = $urandom_range(16, 96);
        stall_bits = efd_pkg::byte_t'($urandom) | 8'h01;
      end
      left--;
      case (mode)
        TakeAll: res_if.ready <= 1'b1;
        TakeCoin: res_if.ready <= 1'($urandom_range(0, 1));
        TakeMost: res_if.ready <= ($urandom_range(0, 3) != 0);
        default: res_if.ready <= stall_bits[left[2:0]];
      endcase
    end
  end

  task automatic write_regs(input efd_pkg::byte_t start_v, input efd_pkg::byte_t esc_v,
                            input efd_pkg::byte_t pad_v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= efd_pkg::CfgStart;
    cfg_wdata_i <= start_v;
    @(posedge clk_i);
    cfg_idx_i <= efd_pkg::CfgEscape;
    cfg_wdata_i <= esc_v;
    @(posedge clk_i);
    cfg_idx_i <= efd_pkg::CfgPad;
    cfg_wdata_i <= pad_v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    fd.set_reg(efd_pkg::CfgStart, start_v);
    fd.set_reg(efd_pkg::CfgEscape, esc_v);
    fd.set_reg(efd_pkg::CfgPad, pad_v);
  endtask

  task automatic send_byte(input efd_pkg::byte_t b);
    rx_if.valid <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk_i); while (!rx_if.ready);
    fd.decode_byte(b);
  endtask

  task automatic send_raw(input bit gapless);
    int unsigned burst;
    burst = $urandom_range(1, 16);
    while (raw_q.size() != 0) begin
      if (!gapless && burst == 0) begin
        rx_if.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        burst = $urandom_range(1, 16);
      end
      send_byte(raw_q.pop_front());
      if (burst != 0) burst--;
    end
  endtask

  task automatic drain();
    rx_if.valid <= 1'b0;
    while (fd.due_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // stuffs one frame byte; start and escape values, and a random share of the others, go out escaped when possible
  function automatic void push_coded(efd_pkg::byte_t b, int unsigned esc_pct);
    efd_pkg::byte_t alt;
    alt = b ^ fd.pad;
    if ((b == fd.start_val || b == fd.esc_val || $urandom_range(0, 99) < esc_pct)
        && fd.esc_val != fd.start_val && alt != fd.start_val) begin
      raw_q.push_back(fd.esc_val);
      raw_q.push_back(alt);
    end else begin
      raw_q.push_back(b);
    end
  endfunction

  function automatic void build_frame(efd_pkg::word_t len, bit bad_sum, int unsigned esc_pct,
                                      int src_sel, int unsigned cap);
    efd_pkg::byte_t b;
    efd_pkg::byte_t sum;
    int unsigned n;
    raw_q.push_back(fd.start_val);
    push_coded(len[15:8], esc_pct);
    push_coded(len[7:0], esc_pct);
    sum = '0;
    for (int i = 0; i < 6; i++) begin
      b = (i == 0 && src_sel >= 0) ? efd_pkg::byte_t'(src_sel) : efd_pkg::byte_t'($urandom);
      sum = sum + b;
      push_coded(b, esc_pct);
    end
    n = (len >= efd_pkg::MinLength) ? 32'(len - efd_pkg::MinLength) : 32'd0;
    if (n > cap) n = cap;
    repeat (n) begin
      b = efd_pkg::byte_t'($urandom);
      sum = sum + b;
      push_coded(b, esc_pct);
    end
    b = efd_pkg::ChecksumBase - sum;
    if (bad_sum) b = b ^ efd_pkg::byte_t'(1 << $urandom_range(0, 7));
    push_coded(b, esc_pct);
  endfunction

  task automatic run_random(input int unsigned target);
    int unsigned sent;
    int unsigned pick;
    int unsigned keep;
    efd_pkg::word_t len;
    sent = 0;
    while (sent < target) begin
      pick = $urandom_range(0, 19);
      if (pick < 2) begin
        // noise, mostly between frames
        repeat ($urandom_range(1, 6)) raw_q.push_back(efd_pkg::byte_t'($urandom));
        send_raw(1'b0);
        continue;
      end
      if (sent == 0) begin
        len = 16'd70;
        hold_req = 1'b1;
      end else if (pick < 5) begin
        len = efd_pkg::word_t'($urandom);
      end else if (pick < 8) begin
        len = efd_pkg::word_t'($urandom_range(0, 6));
      end else if (pick < 10) begin
        len = efd_pkg::word_t'($urandom_range(7, 90));
      end else begin
        len = efd_pkg::word_t'($urandom_range(7, 31));
      end
      build_frame(len, $urandom_range(0, 4) == 0,
                  ($urandom_range(0, 3) == 0) ? 100 : $urandom_range(0, 20), -1, 24);
      if (sent != 0 && pick < 5) begin
        // broken frame: cut short, sometimes ending on an escape
        keep = $urandom_range(2, raw_q.size() - 1);
        while (raw_q.size() > keep) void'(raw_q.pop_back());
        if ($urandom_range(0, 1) == 1) raw_q.push_back(fd.esc_val);
      end
      sent += raw_q.size();
      send_raw($urandom_range(0, 4) == 0);
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= efd_pkg::CfgStart;
    cfg_wdata_i <= '0;
    rx_if.valid <= 1'b0;
    rx_if.rx_byte <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_regs(efd_pkg::ResetStart, efd_pkg::ResetEscape, efd_pkg::ResetPad);

    // hunting noise, start inside a frame, start after an escape
    raw_q = '{fd.esc_val, 8'h00, 8'hFF, fd.start_val, 8'h00, fd.start_val, fd.esc_val};
    // fully escaped empty frame, source decodes from escape after escape
    build_frame(efd_pkg::MinLength, 1'b0, 100, int'(fd.esc_val ^ fd.pad), 0);
    // short length with a bad checksum
    build_frame(16'd3, 1'b1, 0, -1, 0);
    build_frame(16'd9, 1'b0, 0, -1, 2);
    send_raw(1'b1);
    drain();

    write_regs(8'h00, 8'hFF, 8'hFF);
    run_random(PhaseBytes);
    drain();
    write_regs(8'hFF, 8'h00, 8'h00);
    run_random(PhaseBytes);
    drain();
    write_regs(8'h55, 8'h55, 8'hAA);
    run_random(PhaseBytes);
    drain();
    write_regs(efd_pkg::byte_t'($urandom), efd_pkg::byte_t'($urandom),
               efd_pkg::byte_t'($urandom));
    run_random(PhaseBytes);
    drain();

    // longest length field, payload cut short
    write_regs(efd_pkg::ResetStart, efd_pkg::ResetEscape, efd_pkg::ResetPad);
    build_frame(16'hFFFF, 1'b0, 5, -1, 24);
    send_raw(1'b1);
    drain();

    if (fd.failures == 0 && fd.due_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
